// ===== src/rlela_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rlela_pkg;

  // Coding limits.
  localparam int unsigned MAX_RUN    = 256;
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned RUN_MIN    = 5;
  localparam int unsigned LIT_MAX    = 4;
  localparam int unsigned WIN_DEPTH  = LIT_MAX + RUN_MIN;
  localparam int unsigned CMD_BYTES  = LIT_MAX + 1;

  // Derived widths.
  localparam int unsigned FILL_W     = $clog2(WIN_DEPTH + 1);
  localparam int unsigned RUN_W      = $clog2(MAX_RUN + 1);
  localparam int unsigned LEN_W      = $clog2(CMD_BYTES + 1);
  localparam int unsigned OUT_TOT_W  = COUNT_BITS + 1;
  localparam int unsigned OUT_SUM_W  = OUT_TOT_W + 1;

  // Command queue between front and back.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       expanded;
  } out_rsp_t;

  // One coding decision: up to five bytes to send, lowest index first.
  typedef struct packed {
    logic [CMD_BYTES-1:0][7:0] bytes;
    logic [LEN_W-1:0]          len;
    logic                      last;
    logic                      expanded;
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/rlela_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rlela_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rlela_pkg::in_req_t in_req_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output rlela_pkg::cmd_t    cmd_o
);
  import rlela_pkg::*;

  logic [WIN_DEPTH-1:0][7:0] win_q, win_d;
  logic [FILL_W-1:0]         fill_q, fill_d;
  logic [RUN_W-1:0]          rl_q, rl_d;
  logic [7:0]                sym_q, sym_d;
  logic [COUNT_BITS-1:0]     in_tot_q, in_tot_d;
  logic [OUT_TOT_W-1:0]      out_tot_q, out_tot_d;
  logic                      flush_q, flush_d;

  logic                      dec_active;
  logic                      accept;
  logic                      lead_ok;
  logic [FILL_W-1:0]         lead;
  logic [LIT_MAX:1]          lit_hit;
  logic [FILL_W-1:0]         lit_k;
  logic                      is_run;
  logic [FILL_W-1:0]         drop_n;
  logic [WIN_DEPTH-1:0][7:0] win_drop;
  logic [FILL_W-1:0]         fill_drop;
  logic                      run_close;
  logic [RUN_W-1:0]          rl_inc;
  logic [COUNT_BITS-1:0]     in_tot_inc;
  logic [OUT_SUM_W-1:0]      out_sum;
  logic [OUT_TOT_W-1:0]      out_tot_new;
  logic                      stream_end;

  // A decision is pending when the window is full with no open run, or while flushing.
  assign dec_active = flush_q || ((rl_q == '0) && (fill_q >= FILL_W'(WIN_DEPTH)));
  assign in_ready_o = !dec_active && cmd_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Count the bytes equal to the head of the window.
  always_comb begin
    lead    = FILL_W'(1);
    lead_ok = 1'b1;
    for (int i = 1; i < WIN_DEPTH; i++) begin
      if (lead_ok && (FILL_W'(i) < fill_q) && (i < MAX_RUN) && (win_q[i] == win_q[0])) begin
        lead = FILL_W'(i + 1);
      end else begin
        lead_ok = 1'b0;
      end
    end
  end

  // Literal group of k bytes qualifies when a run of five starts right after it.
  always_comb begin
    for (int k = 1; k <= LIT_MAX; k++) begin
      lit_hit[k] = (FILL_W'(k + RUN_MIN - 1) < fill_q);
      for (int j = 1; j < RUN_MIN; j++) begin
        if (win_q[k + j] != win_q[k]) begin
          lit_hit[k] = 1'b0;
        end
      end
    end
  end

  // Longest qualifying group wins; otherwise take up to four bytes.
  always_comb begin
    lit_k = (fill_q < FILL_W'(LIT_MAX)) ? fill_q : FILL_W'(LIT_MAX);
    for (int k = 1; k <= LIT_MAX; k++) begin
      if (lit_hit[k]) begin
        lit_k = FILL_W'(k);
      end
    end
  end

  assign is_run    = (lead >= FILL_W'(RUN_MIN));
  assign drop_n    = is_run ? lead : lit_k;
  assign fill_drop = fill_q - drop_n;
  assign run_close = (fill_drop != '0) || (RUN_W'(lead) >= RUN_W'(MAX_RUN)) || flush_q;

  // Window with the decided bytes removed from the front.
  always_comb begin
    win_drop = '0;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      for (int s = 0; s <= WIN_DEPTH; s++) begin
        if ((drop_n == FILL_W'(s)) && (i + s < WIN_DEPTH)) begin
          win_drop[i] = win_q[i + s];
        end
      end
    end
  end

  assign rl_inc     = rl_q + 1'b1;
  assign in_tot_inc = (&in_tot_q) ? in_tot_q : in_tot_q + 1'b1;

  // Stream state update and command generation.
  always_comb begin
    win_d       = win_q;
    fill_d      = fill_q;
    rl_d        = rl_q;
    sym_d       = sym_q;
    in_tot_d    = in_tot_q;
    out_tot_d   = out_tot_q;
    flush_d     = flush_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '0;
    stream_end  = 1'b0;

    if (accept) begin
      in_tot_d = in_tot_inc;
      if ((rl_q != '0) && (in_req_i.data_byte == sym_q)) begin
        // The byte extends the open run.
        if ((rl_inc >= RUN_W'(MAX_RUN)) || in_req_i.last_in) begin
          cmd_valid_o    = 1'b1;
          cmd_o.bytes[0] = 8'(rl_inc - 1'b1);
          cmd_o.bytes[1] = sym_q;
          cmd_o.len      = LEN_W'(2);
          rl_d           = '0;
        end else begin
          rl_d = rl_inc;
        end
      end else begin
        if (rl_q != '0) begin
          // A different byte closes the open run.
          cmd_valid_o    = 1'b1;
          cmd_o.bytes[0] = 8'(rl_q - 1'b1);
          cmd_o.bytes[1] = sym_q;
          cmd_o.len      = LEN_W'(2);
          rl_d           = '0;
        end
        for (int i = 0; i < WIN_DEPTH; i++) begin
          if (fill_q == FILL_W'(i)) begin
            win_d[i] = in_req_i.data_byte;
          end
        end
        fill_d = fill_q + 1'b1;
      end
      if (in_req_i.last_in) begin
        if (fill_d == '0) begin
          stream_end = 1'b1;
        end else begin
          flush_d = 1'b1;
        end
      end
    end else if (dec_active && cmd_ready_i) begin
      win_d  = win_drop;
      fill_d = fill_drop;
      if (is_run) begin
        if (run_close) begin
          cmd_valid_o    = 1'b1;
          cmd_o.bytes[0] = 8'(lead - 1'b1);
          cmd_o.bytes[1] = win_q[0];
          cmd_o.len      = LEN_W'(2);
        end else begin
          // The run reaches the end of the window and stays open.
          rl_d  = RUN_W'(lead);
          sym_d = win_q[0];
        end
      end else begin
        cmd_valid_o    = 1'b1;
        cmd_o.bytes[0] = 8'(lit_k - 1'b1);
        for (int j = 1; j <= LIT_MAX; j++) begin
          if (FILL_W'(j) <= lit_k) begin
            cmd_o.bytes[j] = win_q[j - 1];
          end
        end
        cmd_o.len = LEN_W'(lit_k + 1'b1);
      end
      if (flush_q && (fill_drop == '0)) begin
        stream_end = 1'b1;
      end
    end

    // Saturating count of encoded bytes.
    out_sum     = {1'b0, out_tot_q} + OUT_SUM_W'(cmd_o.len);
    out_tot_new = out_sum[OUT_TOT_W] ? '1 : out_sum[OUT_TOT_W-1:0];
    if (cmd_valid_o) begin
      out_tot_d = out_tot_new;
    end

    // The final command carries the size flag, and the stream starts over.
    if (stream_end) begin
      cmd_o.last     = 1'b1;
      cmd_o.expanded = (out_tot_new >= {1'b0, in_tot_d});
      win_d          = '0;
      fill_d         = '0;
      rl_d           = '0;
      sym_d          = '0;
      in_tot_d       = '0;
      out_tot_d      = '0;
      flush_d        = 1'b0;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= '0;
      fill_q    <= '0;
      rl_q      <= '0;
      sym_q     <= '0;
      in_tot_q  <= '0;
      out_tot_q <= '0;
      flush_q   <= 1'b0;
    end else begin
      win_q     <= win_d;
      fill_q    <= fill_d;
      rl_q      <= rl_d;
      sym_q     <= sym_d;
      in_tot_q  <= in_tot_d;
      out_tot_q <= out_tot_d;
      flush_q   <= flush_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/rlela_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rlela_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  rlela_pkg::cmd_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output rlela_pkg::cmd_t pop_data_o
);
  import rlela_pkg::*;

  cmd_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = (cnt_q != CNT_W'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/rlela_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rlela_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  rlela_pkg::cmd_t     cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rlela_pkg::out_rsp_t out_rsp_o
);
  import rlela_pkg::*;

  logic [CMD_BYTES-1:0][7:0] bytes_q, bytes_d;
  logic [LEN_W-1:0]          rem_q, rem_d;
  logic                      last_q, last_d;
  logic                      exp_q, exp_d;
  logic                      out_valid_q, out_valid_d;
  out_rsp_t                  out_q, out_d;
  logic                      load;
  logic                      final_byte;

  // The output register takes a new byte when it is empty or being drained.
  assign load        = !out_valid_q || out_ready_i;
  assign cmd_ready_o = load && (rem_q == '0);
  assign final_byte  = (rem_q == LEN_W'(1));

  // Serialize the current command one byte per cycle while the receiver takes bytes.
  always_comb begin
    bytes_d     = bytes_q;
    rem_d       = rem_q;
    last_d      = last_q;
    exp_d       = exp_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load) begin
      if (rem_q != '0) begin
        out_d.out_byte = bytes_q[0];
        out_d.out_last = last_q && final_byte;
        out_d.expanded = exp_q && final_byte;
        bytes_d        = bytes_q >> 8;
        rem_d          = rem_q - 1'b1;
        out_valid_d    = 1'b1;
      end else if (cmd_valid_i) begin
        out_d.out_byte = cmd_i.bytes[0];
        out_d.out_last = cmd_i.last && (cmd_i.len == LEN_W'(1));
        out_d.expanded = cmd_i.expanded && (cmd_i.len == LEN_W'(1));
        bytes_d        = cmd_i.bytes >> 8;
        rem_d          = cmd_i.len - 1'b1;
        last_d         = cmd_i.last;
        exp_d          = cmd_i.expanded;
        out_valid_d    = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    last_q  <= last_d;
    exp_q   <= exp_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

// ===== src/rle_lookahead_encoder_unit.sv =====
// Byte run-length encoder with a nine-byte lookahead window.
// Input channel: one raw byte per request (in_valid_i / in_ready_o); last_in
// ends the buffer and flushes the window. Output channel: one encoded byte per
// request (out_valid_o / out_ready_i); out_last marks the final byte of the
// buffer and expanded then tells whether the encoding is not shorter than the input.
// Throughput: the front takes one byte per cycle while the window holds fewer
// than nine bytes and the queue has room; it takes no byte while a coding
// decision is made. The back sends one encoded byte per cycle while the
// receiver is ready, which bounds the sustained rate at the number of encoded bytes.
// Path: once the byte completing the window is accepted, the front decides and
// writes the command into the queue, and the back then loads its first byte into
// the output register; a command for a run closed by a different byte is written
// into the queue by the edge that accepts that byte and then takes the same path.
// The front and back are joined by a four-entry command queue; when the receiver
// stalls, the queue fills and the front then holds in_ready_o low.
// Reset is asynchronous: the window empties, all counters clear and no output
// is pending. After the final byte of a buffer the stream state starts over.
`timescale 1ns / 1ps
`default_nettype none

module rle_lookahead_encoder_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rlela_pkg::in_req_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rlela_pkg::out_rsp_t out_rsp_o
);
  import rlela_pkg::*;

  logic cmd_push_valid;
  logic cmd_push_ready;
  cmd_t cmd_push;
  logic cmd_pop_valid;
  logic cmd_pop_ready;
  cmd_t cmd_pop;

  // Window, run tracking and coding decisions.
  rlela_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .cmd_valid_o (cmd_push_valid),
    .cmd_ready_i (cmd_push_ready),
    .cmd_o       (cmd_push)
  );

  // Command queue.
  rlela_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_push_valid),
    .push_ready_o (cmd_push_ready),
    .push_data_i  (cmd_push),
    .pop_valid_o  (cmd_pop_valid),
    .pop_ready_i  (cmd_pop_ready),
    .pop_data_o   (cmd_pop)
  );

  // Byte serializer and output register.
  rlela_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_pop_valid),
    .cmd_ready_o (cmd_pop_ready),
    .cmd_i       (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire
